[hdl/multi_key_record_insertion_sorter_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the multi-key record insertion sorter
// ---------------------------------------------------------------------------
`ifndef MULTI_KEY_RECORD_INSERTION_SORTER_MACROS_SVH
`define MULTI_KEY_RECORD_INSERTION_SORTER_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define MKRIS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define MKRIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mkris_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mkris_pkg
// Shared constants, record type and key compare for the record sorter.
// ---------------------------------------------------------------------------
package mkris_pkg;

    localparam int STORE_DEPTH = 32;

    localparam int W_SURNAME = 64;
    localparam int W_JOB     = 64;
    localparam int W_DAY     = 5;
    localparam int W_MONTH   = 4;
    localparam int W_YEAR    = 14;
    localparam int W_EXP     = 7;
    localparam int W_SALARY  = 24;

    typedef struct packed {
        logic [W_SURNAME-1:0] surname;
        logic [W_JOB-1:0]     job_title;
        logic [W_DAY-1:0]     birth_day;
        logic [W_MONTH-1:0]   birth_month;
        logic [W_YEAR-1:0]    birth_year;
        logic [W_EXP-1:0]     experience;
        logic [W_SALARY-1:0]  salary;
    } t_record;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // insert the broadcast record
        logic shift;  // drain: move every record one cell toward cell 0
    } t_cell_ctl;

    // What a cell shows its neighbors
    typedef struct packed {
        logic    valid;
        logic    take;   // cell is taking part in the current insert shift
        t_record rec;
    } t_link;

    // True when stored record a sorts strictly after new record b.
    function automatic logic rec_after(input t_record a, input t_record b);
        logic [W_SURNAME+W_EXP+W_YEAR-1:0] ka;
        logic [W_SURNAME+W_EXP+W_YEAR-1:0] kb;
        ka = {a.surname, a.experience, a.birth_year};
        kb = {b.surname, b.experience, b.birth_year};
        return ka > kb;
    endfunction

endpackage

[hdl/mkris_rec_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mkris_rec_if
// Input record channel: valid/ready handshake with one employee record.
// ---------------------------------------------------------------------------
interface mkris_rec_if;
    import mkris_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [W_SURNAME-1:0] surname;
    logic [W_JOB-1:0]     job_title;
    logic [W_DAY-1:0]     birth_day;
    logic [W_MONTH-1:0]   birth_month;
    logic [W_YEAR-1:0]    birth_year;
    logic [W_EXP-1:0]     experience;
    logic [W_SALARY-1:0]  salary;
    logic                 final_record;

    modport source (
        output valid, surname, job_title, birth_day, birth_month,
               birth_year, experience, salary, final_record,
        input  ready
    );

    modport sink (
        input  valid, surname, job_title, birth_day, birth_month,
               birth_year, experience, salary, final_record,
        output ready
    );
endinterface

[hdl/mkris_res_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mkris_res_if
// Result channel: valid/ready handshake with one sorted record.
// ---------------------------------------------------------------------------
interface mkris_res_if;
    import mkris_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [W_SURNAME-1:0] out_surname;
    logic [W_JOB-1:0]     out_job_title;
    logic [W_DAY-1:0]     out_birth_day;
    logic [W_MONTH-1:0]   out_birth_month;
    logic [W_YEAR-1:0]    out_birth_year;
    logic [W_EXP-1:0]     out_experience;
    logic [W_SALARY-1:0]  out_salary;
    logic                 out_last;
    logic                 overflowed;

    modport source (
        output valid, out_surname, out_job_title, out_birth_day, out_birth_month,
               out_birth_year, out_experience, out_salary, out_last, overflowed,
        input  ready
    );

    modport sink (
        input  valid, out_surname, out_job_title, out_birth_day, out_birth_month,
               out_birth_year, out_experience, out_salary, out_last, overflowed,
        output ready
    );
endinterface

[hdl/multi_key_record_insertion_sorter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_key_record_insertion_sorter
// Stable insertion sorter for employee records on a chain of compare cells.
// ---------------------------------------------------------------------------
// Records arrive one per transaction and are kept sorted by surname, then
// experience, then birth year, all ascending as unsigned numbers; records
// with equal keys stay in arrival order. While loading, the block takes one
// record every cycle: the record is broadcast to all STORE_DEPTH cells, each
// compares it with its own record, and the cells behind the insert point
// shift by one, all in the same cycle. When the store is full an arriving
// record is dropped and remembered in the overflowed flag. A record marked
// final_record is inserted like any other and then starts the drain: the
// stored records leave through cell 0, one per cycle while the sink takes
// them, and no new record is taken while the run drains. out_last marks
// the final record of the run and overflowed carries the same value on
// every record of it. The next set may begin as soon as the last record
// is in the output register. Valid flags clear at reset, so no clearing
// pass is needed.
// ---------------------------------------------------------------------------
module multi_key_record_insertion_sorter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mkris_rec_if.sink   i_rec,
    mkris_res_if.source o_res
);
    import mkris_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state    r_state,     n_state;
    logic      r_dropped,   n_dropped;
    logic      r_out_valid, n_out_valid;
    t_record   r_out_rec;
    logic      r_out_last;
    logic      r_out_ovf;

    t_record   w_new;
    t_cell_ctl w_ctl;
    t_link     w_link [STORE_DEPTH];
    t_link     w_prev [STORE_DEPTH];
    t_link     w_next [STORE_DEPTH];
    logic      w_accept;
    logic      w_full;
    logic      w_out_load;
    logic      w_run_last;

    // Incoming record, broadcast to the chain
    assign w_new.surname     = i_rec.surname;
    assign w_new.job_title   = i_rec.job_title;
    assign w_new.birth_day   = i_rec.birth_day;
    assign w_new.birth_month = i_rec.birth_month;
    assign w_new.birth_year  = i_rec.birth_year;
    assign w_new.experience  = i_rec.experience;
    assign w_new.salary      = i_rec.salary;

    assign i_rec.ready = (r_state == ST_LOAD);
    assign w_accept    = i_rec.valid && i_rec.ready;

    // valid cells form a prefix, so the tail cell tells full
    assign w_full = w_link[STORE_DEPTH-1].valid;

    // Output register refills while draining whenever it is empty or taken
    assign w_out_load = (r_state == ST_DRAIN) && (!r_out_valid || o_res.ready);
    // record in cell 0 is the last one when cell 1 is empty
    assign w_run_last = !w_link[1].valid;

    assign w_ctl.ins   = w_accept && !w_full;
    assign w_ctl.shift = w_out_load;

    // Cell chain: cell 0 is the head (smallest keys)
    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_prev[gi] = '{valid: 1'b1, take: 1'b0, rec: '0};
            end else begin : g_body
                assign w_prev[gi] = w_link[gi-1];
            end

            if (gi == STORE_DEPTH - 1) begin : g_tail
                assign w_next[gi] = '{valid: 1'b0, take: 1'b0, rec: w_link[gi].rec};
            end else begin : g_inner
                assign w_next[gi] = w_link[gi+1];
            end

            mkris_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_new   (w_new),
                .i_prev  (w_prev[gi]),
                .i_next  (w_next[gi]),
                .o_link  (w_link[gi])
            );
        end
    endgenerate

    // Control
    always_comb begin
        n_state     = r_state;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end
                    if (i_rec.final_record) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    if (w_run_last) begin
                        n_state   = ST_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_rec  <= w_link[0].rec;
            r_out_last <= w_run_last;
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.out_surname     = r_out_rec.surname;
    assign o_res.out_job_title   = r_out_rec.job_title;
    assign o_res.out_birth_day   = r_out_rec.birth_day;
    assign o_res.out_birth_month = r_out_rec.birth_month;
    assign o_res.out_birth_year  = r_out_rec.birth_year;
    assign o_res.out_experience  = r_out_rec.experience;
    assign o_res.out_salary      = r_out_rec.salary;
    assign o_res.out_last        = r_out_last;
    assign o_res.overflowed      = r_out_ovf;
endmodule

[hdl/mkris_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mkris_cell
// One slot of the sorting chain: holds a record, compares it with the
// broadcast record and shifts toward either neighbor.
// ---------------------------------------------------------------------------
module mkris_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mkris_pkg::t_cell_ctl i_ctl,
    input  mkris_pkg::t_record   i_new,
    input  mkris_pkg::t_link     i_prev,
    input  mkris_pkg::t_link     i_next,
    output mkris_pkg::t_link     o_link
);
    import mkris_pkg::*;

    logic    r_valid;
    t_record r_rec;
    logic    w_after;
    logic    w_take;

    assign w_after = r_valid && rec_after(r_rec, i_new);
    // first empty cell takes too; empty cells past it stay out
    assign w_take  = w_after || (!r_valid && i_prev.valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins && w_take) begin
            r_valid <= 1'b1;
        end else if (i_ctl.shift) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && w_take) begin
            r_rec <= i_prev.take ? i_prev.rec : i_new;
        end else if (i_ctl.shift) begin
            r_rec <= i_next.rec;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.take  = w_take;
    assign o_link.rec   = r_rec;
endmodule

[hdl/mkris_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mkris_checker
// Port-level checks for the record sorter, bound to the top level.
// ---------------------------------------------------------------------------
`include "multi_key_record_insertion_sorter_macros.svh"

module mkris_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_final,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_surname,
    input logic        i_out_last,
    input logic        i_out_ovf
);
    // stalled result holds
    `MKRIS_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_surname) && $stable(i_out_last) && $stable(i_out_ovf)), "result changed while stalled")

    // a final record closes the input until the run is out
    `MKRIS_ASSERT(a_final_blocks, i_clk, i_rst_n, (i_in_valid && i_in_ready && i_in_final) |=> !i_in_ready, "record taken right after final record")

    // mid-run result pending means no input is taken
    `MKRIS_ASSERT(a_run_closed, i_clk, i_rst_n, (i_out_valid && !i_out_last) |-> !i_in_ready, "input open during sorted run")

    // reset empties the output and opens the input
    `MKRIS_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!i_out_valid && i_in_ready), "bad state after reset")
endmodule

bind multi_key_record_insertion_sorter mkris_checker u_mkris_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_rec.valid),
    .i_in_ready    (i_rec.ready),
    .i_in_final    (i_rec.final_record),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_surname (o_res.out_surname),
    .i_out_last    (o_res.out_last),
    .i_out_ovf     (o_res.overflowed)
);

[verif/multi_key_record_insertion_sorter_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_key_record_insertion_sorter_tb
// Self-checking bench for the multi-key record insertion sorter.
// ---------------------------------------------------------------------------
// Employee records are fed in sets over the record channel. Each set ends
// with a record marked final_record, and the sorted run that comes back is
// checked record by record against a software roster. The roster keeps
// records ordered by surname, experience and birth year, keeps arrival order
// on ties, and drops records once the store is full. A few directed sets
// cover field extremes, key ties and out-of-range values. Random sets follow,
// some of them overflowing the store. Both channel ends insert random idle
// cycles, with quiet stretches mixed in.
// ---------------------------------------------------------------------------
module multi_key_record_insertion_sorter_tb;
    import mkris_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RST_CYCLES  = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TARGET_RECS = 450;
    localparam int SETTLE      = 40;

    // One expected sorted-run entry
    typedef struct {
        t_record rec;
        bit      last;
        bit      ovf;
    } t_emit;

    // -----------------------------------------------------------------------
    // Roster: mirrors the sorted store and queues up the runs it will emit
    // -----------------------------------------------------------------------
    class roster_board;
        t_record roster[$];     // sorted store contents
        bit      dropped;       // some record of this set did not fit
        t_emit   pending[$];    // sorted records still due on the output
        int      errors;

        // Stored record a goes strictly after arriving record b
        function bit sorts_after(t_record a, t_record b);
            if (a.surname != b.surname)
                return a.surname > b.surname;
            if (a.experience != b.experience)
                return a.experience > b.experience;
            return a.birth_year > b.birth_year;
        endfunction

        // Called on every accepted record transaction
        function void take_record(t_record r, bit fin);
            int    pos;
            t_emit e;
            if (roster.size() >= STORE_DEPTH) begin
                dropped = 1'b1;
            end else begin
                pos = 0;
                while (pos < roster.size() && !sorts_after(roster[pos], r))
                    pos++;
                roster.insert(pos, r);
            end
            if (fin) begin
                foreach (roster[k]) begin
                    e.rec  = roster[k];
                    e.last = (k == roster.size() - 1);
                    e.ovf  = dropped;
                    pending = {pending, e};
                end
                roster.delete();
                dropped = 1'b0;
            end
        endfunction

        function void field_ok(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Called on every accepted result transaction
        function void match_emitted(t_record got, logic last, logic ovf);
            t_emit e;
            if (pending.size() == 0) begin
                $error("unexpected result: surname %0h", got.surname);
                errors++;
                return;
            end
            e = pending.pop_front();
            field_ok("out_surname",     e.rec.surname,          got.surname);
            field_ok("out_job_title",   e.rec.job_title,        got.job_title);
            field_ok("out_birth_day",   64'(e.rec.birth_day),   64'(got.birth_day));
            field_ok("out_birth_month", 64'(e.rec.birth_month), 64'(got.birth_month));
            field_ok("out_birth_year",  64'(e.rec.birth_year),  64'(got.birth_year));
            field_ok("out_experience",  64'(e.rec.experience),  64'(got.experience));
            field_ok("out_salary",      64'(e.rec.salary),      64'(got.salary));
            field_ok("out_last",        64'(e.last),            64'(last));
            field_ok("overflowed",      64'(e.ovf),             64'(ovf));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mkris_rec_if rec_if();
    mkris_res_if res_if();

    roster_board board = new;

    int cycle_count = 0;
    int recs_sent   = 0;
    bit feed_calm   = 1'b0;   // sender inserts no gaps while set
    bit drain_calm  = 1'b0;   // receiver never stalls while set

    string surname_pool[6] = '{"ADAMS", "BAKER", "SMITH", "SMITHSON", "SMIT", "ZED"};

    multi_key_record_insertion_sorter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_if.sink),
        .o_res   (res_if.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[multi_key_record_insertion_sorter] ERROR");
            $finish;
        end
    end

    // Pack text into a surname/title word: first char in the top byte
    function automatic logic [63:0] name8(string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
            if (i < s.len())
                w[63 - 8*i -: 8] = s[i];
        return w;
    endfunction

    function automatic t_record make_rec(logic [63:0] sur, logic [63:0] job,
                                         int day, int mon, int year, int exp,
                                         int sal);
        t_record r;
        r.surname     = sur;
        r.job_title   = job;
        r.birth_day   = W_DAY'(day);
        r.birth_month = W_MONTH'(mon);
        r.birth_year  = W_YEAR'(year);
        r.experience  = W_EXP'(exp);
        r.salary      = W_SALARY'(sal);
        return r;
    endfunction

    // Random record, biased so that key ties are common
    function automatic t_record random_record();
        t_record r;
        int      pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.surname = name8(surname_pool[$urandom_range(0, 5)]);
        else if (pick < 6)
            r.surname = 64'($urandom_range(0, 3));
        else
            r.surname = {$urandom, $urandom};
        r.job_title = {$urandom, $urandom};

        pick = $urandom_range(0, 9);
        r.birth_day   = (pick < 8) ? W_DAY'($urandom_range(1, 31))
                                   : W_DAY'($urandom_range(0, 31));
        r.birth_month = (pick < 8) ? W_MONTH'($urandom_range(1, 12))
                                   : W_MONTH'($urandom_range(0, 15));

        pick = $urandom_range(0, 9);
        if (pick < 5)
            r.birth_year = W_YEAR'(1980 + $urandom_range(0, 1));
        else if (pick < 8)
            r.birth_year = W_YEAR'($urandom_range(0, 9999));
        else
            r.birth_year = W_YEAR'($urandom_range(0, 16383));

        pick = $urandom_range(0, 9);
        if (pick < 5)
            r.experience = W_EXP'($urandom_range(0, 3));
        else if (pick < 8)
            r.experience = W_EXP'($urandom_range(0, 99));
        else
            r.experience = W_EXP'($urandom_range(0, 127));

        r.salary = W_SALARY'($urandom);
        return r;
    endfunction

    // Drive one record and hold it until the block takes it. Called on a
    // rising edge; returns on the edge at which the transaction happened,
    // leaving valid high so a back-to-back record needs no extra step.
    task automatic send_record(t_record r, bit fin);
        int gap;
        gap = feed_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            rec_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rec_if.valid        <= 1'b1;
        rec_if.surname      <= r.surname;
        rec_if.job_title    <= r.job_title;
        rec_if.birth_day    <= r.birth_day;
        rec_if.birth_month  <= r.birth_month;
        rec_if.birth_year   <= r.birth_year;
        rec_if.experience   <= r.experience;
        rec_if.salary       <= r.salary;
        rec_if.final_record <= fin;
        do @(posedge i_clk); while (rec_if.ready !== 1'b1);
        board.take_record(r, fin);
        recs_sent++;
    endtask

    // A random set of n records; the last one closes the set
    task automatic send_random_set(int n);
        feed_calm  = ($urandom_range(0, 3) == 0);
        drain_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
            send_record(random_record(), i == n - 1);
    endtask

    // Result sink: random stall before each transaction
    initial begin
        int w;
        res_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n === 1'b1);
        forever begin
            w = drain_calm ? 0 : $urandom_range(0, 8);
            if (w > 0) begin
                res_if.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
        end
    end

    // Result monitor: values seen at the edge are the pre-edge ones
    always @(posedge i_clk) begin
        t_record got;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.surname     = res_if.out_surname;
            got.job_title   = res_if.out_job_title;
            got.birth_day   = res_if.out_birth_day;
            got.birth_month = res_if.out_birth_month;
            got.birth_year  = res_if.out_birth_year;
            got.experience  = res_if.out_experience;
            got.salary      = res_if.out_salary;
            board.match_emitted(got, res_if.out_last, res_if.overflowed);
        end
    end

    // Stimulus
    initial begin
        t_record dir[$];
        int      p;
        int      n;

        rec_if.valid        = 1'b0;
        rec_if.surname      = '0;
        rec_if.job_title    = '0;
        rec_if.birth_day    = '0;
        rec_if.birth_month  = '0;
        rec_if.birth_year   = '0;
        rec_if.experience   = '0;
        rec_if.salary       = '0;
        rec_if.final_record = 1'b0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed set: field extremes, out-of-range values, and ties on
        // each key level. The three identical SMITH/5/1980 records must
        // come back in arrival order (told apart by job title).
        dir = {dir, make_rec(name8("SMITH"), name8("CLERK"), 10, 3, 1980, 5, 1000)};
        dir = {dir, make_rec('0, '0, 0, 0, 0, 0, 0)};
        dir = {dir, make_rec('1, '1, 31, 15, 16383, 127, 24'hFFFFFF)};
        dir = {dir, make_rec(name8("SMITH"), name8("TESTER"), 2, 7, 1975, 5, 2000)};
        dir = {dir, make_rec(name8("SMITH"), name8("MANAGER"), 5, 5, 1990, 3, 3000)};
        dir = {dir, make_rec(name8("SMITH"), name8("DRIVER"), 11, 2, 1980, 5, 4000)};
        dir = {dir, make_rec(name8("SMITHSON"), name8("COOK"), 1, 1, 2000, 0, 5000)};
        dir = {dir, make_rec(name8("SMIT"), name8("GUARD"), 9, 9, 1999, 50, 6000)};
        dir = {dir, make_rec(name8("ADAMS"), name8("CHEF"), 31, 12, 9999, 99, 7000)};
        dir = {dir, make_rec(name8("ADAMS"), name8("PILOT"), 1, 1, 9999, 100, 8000)};
        dir = {dir, make_rec(name8("SMITH"), name8("NURSE"), 12, 12, 1980, 5, 9000)};
        dir = {dir, make_rec(name8("ZED"), name8("BAKER"), 1, 1, 1, 1, 1)};
        foreach (dir[i])
            send_record(dir[i], i == dir.size() - 1);

        // One-record set, then a set of two fully tied records
        send_record(make_rec(name8("SOLO"), name8("ADMIN"), 15, 6, 1985, 10, 12345), 1'b1);
        send_record(make_rec(name8("TWIN"), name8("FIRST"), 3, 3, 1970, 7, 100), 1'b0);
        send_record(make_rec(name8("TWIN"), name8("SECOND"), 4, 4, 1970, 7, 200), 1'b1);

        // Random sets: mostly short, some filling the store, a few past it
        // (the closing record is then dropped but still starts the drain)
        while (recs_sent < TARGET_RECS) begin
            p = $urandom_range(0, 9);
            if (p < 6)
                n = $urandom_range(1, 10);
            else if (p < 9)
                n = $urandom_range(11, STORE_DEPTH);
            else
                n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
            send_random_set(n);
        end
        rec_if.valid <= 1'b0;

        // Let the last run drain, then allow stray results to show up
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("[multi_key_record_insertion_sorter] OK");
        else
            $display("[multi_key_record_insertion_sorter] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/mkris_pkg.sv
hdl/mkris_rec_if.sv
hdl/mkris_res_if.sv
hdl/mkris_cell.sv
hdl/multi_key_record_insertion_sorter.sv
hdl/mkris_checker.sv
verif/multi_key_record_insertion_sorter_tb.sv
